FILE: hdl/rsl_pkg.sv
package rsl_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int MAX_PAYLOAD = 32;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD);

  localparam logic [5:0] AGE_AFTER_SEND = 6'd3;
  localparam logic [5:0] AGE_RETX_1 = 6'd10;
  localparam logic [5:0] AGE_RETX_2 = 6'd20;
  localparam logic [5:0] AGE_RETX_3 = 6'd30;
  localparam logic [5:0] AGE_RETX_4 = 6'd40;
  localparam logic [5:0] AGE_FINAL = 6'd50;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SEND = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_ACCEPTED  = 3'd0,
    EV_TOO_LONG  = 3'd1,
    EV_NO_SLOT   = 3'd2,
    EV_RETX      = 3'd3,
    EV_FINAL     = 3'd4,
    EV_ACK_HIT   = 3'd5,
    EV_ACK_MISS  = 3'd6,
    EV_UNUSED    = 3'd7
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [5:0]  age;
    logic [15:0] seq;
  } slot_t;

  function automatic logic [2:0] slot_field(input logic [IDX_W-1:0] idx);
    logic [IDX_W+2:0] wide;
    wide = (IDX_W + 3)'(idx);
    return wide[2:0];
  endfunction

endpackage

FILE: hdl/retransmit_slot_table.sv
// Each item scans the slot memory at one slot per cycle and then finishes; an oversized send
// or an unknown action skips the scan. busy is high throughout; no new item is taken meanwhile.
// Results are registered and cannot be stalled by the receiver.
// Synchronous reset frees every slot at once and sets the sequence counter to one; the stored
// numbers are not cleared but read as zero while their slot is free, so no clearing pass is needed.
module retransmit_slot_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [7:0]  payload_len,
  input  logic [15:0] ack_seq,
  output logic        strobe,
  output logic [2:0]  event_res,
  output logic [2:0]  slot_index,
  output logic [15:0] seq_out,
  output logic        last
);
  import rsl_pkg::*;

  slot_t mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld;
  slot_t rd_data;
  logic  rd_vld;

  state_t state, state_next;
  action_t act, act_next;
  logic [7:0] len, len_next;
  logic [15:0] ack, ack_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic proc_v, proc_v_next;
  logic [IDX_W-1:0] proc_idx, proc_idx_next;
  logic found, found_next;
  logic [IDX_W-1:0] found_idx, found_idx_next;
  logic [15:0] found_seq, found_seq_next;
  logic pend_v, pend_v_next;
  event_t pend_ev, pend_ev_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;
  logic [15:0] pend_seq, pend_seq_next;
  logic [15:0] seq_counter, seq_counter_next;

  logic mem_re, mem_we;
  logic [IDX_W-1:0] mem_ra, mem_wa;
  slot_t mem_wd;

  logic res_v, res_last;
  event_t res_ev;
  logic [2:0] res_idx;
  logic [15:0] res_seq;

  logic [5:0] cur_age, age_inc, age_new;
  logic [15:0] cur_seq, seq_draw;
  logic is_retx, is_final;

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[mem_wa] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld <= vld[mem_ra];
      end
    end
  end

  assign cur_age = rd_vld ? rd_data.age : 6'd0;
  assign cur_seq = rd_vld ? rd_data.seq : 16'd0;
  assign age_inc = cur_age + 6'd1;
  assign is_retx = (age_inc == AGE_RETX_1) || (age_inc == AGE_RETX_2) ||
                   (age_inc == AGE_RETX_3) || (age_inc == AGE_RETX_4);
  assign is_final = (age_inc >= AGE_FINAL) || (age_inc == 6'd0);
  assign seq_draw = seq_counter[0] ? seq_counter + 16'd2 : seq_counter + 16'd1;

  always_comb begin
    if (is_retx) begin
      age_new = age_inc + 6'd1;
    end else if (is_final) begin
      age_new = 6'd0;
    end else begin
      age_new = age_inc;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if ((action == ACT_NONE) || ((action == ACT_SEND) && (payload_len > LEN_MAX))) begin
            state_next = ST_FIN;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (proc_v && (rd_idx == CNT_W'(SLOT_COUNT))) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    act_next = act;
    len_next = len;
    ack_next = ack;
    rd_idx_next = rd_idx;
    proc_v_next = proc_v;
    proc_idx_next = proc_idx;
    found_next = found;
    found_idx_next = found_idx;
    found_seq_next = found_seq;
    pend_v_next = pend_v;
    pend_ev_next = pend_ev;
    pend_idx_next = pend_idx;
    pend_seq_next = pend_seq;
    seq_counter_next = seq_counter;
    mem_re = 1'b0;
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    res_v = 1'b0;
    res_ev = EV_ACCEPTED;
    res_idx = 3'd0;
    res_seq = 16'd0;
    res_last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          act_next = action_t'(action);
          len_next = payload_len;
          ack_next = ack_seq;
          rd_idx_next = '0;
          proc_v_next = 1'b0;
          found_next = 1'b0;
          pend_v_next = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_idx != CNT_W'(SLOT_COUNT)) begin
          mem_re = 1'b1;
          mem_ra = rd_idx[IDX_W-1:0];
          rd_idx_next = rd_idx + CNT_W'(1);
          proc_v_next = 1'b1;
          proc_idx_next = rd_idx[IDX_W-1:0];
        end else begin
          proc_v_next = 1'b0;
        end
        if (proc_v) begin
          case (act)
            ACT_TICK: begin
              mem_we = 1'b1;
              mem_wa = proc_idx;
              mem_wd = '{age: (cur_age == 6'd0) ? 6'd0 : age_new, seq: cur_seq};
              if ((cur_age != 6'd0) && (is_retx || is_final)) begin
                if (pend_v) begin
                  res_v = 1'b1;
                  res_ev = pend_ev;
                  res_idx = slot_field(pend_idx);
                  res_seq = pend_seq;
                end
                pend_v_next = 1'b1;
                pend_ev_next = is_retx ? EV_RETX : EV_FINAL;
                pend_idx_next = proc_idx;
                pend_seq_next = cur_seq;
              end
            end
            ACT_SEND: begin
              if (!found && (cur_age == 6'd0)) begin
                found_next = 1'b1;
                found_idx_next = proc_idx;
              end
            end
            ACT_ACK: begin
              if (!found && (cur_seq == ack)) begin
                found_next = 1'b1;
                found_idx_next = proc_idx;
                found_seq_next = cur_seq;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FIN: begin
        res_last = 1'b1;
        case (act)
          ACT_TICK: begin
            res_v = pend_v;
            res_ev = pend_ev;
            res_idx = slot_field(pend_idx);
            res_seq = pend_seq;
            pend_v_next = 1'b0;
          end
          ACT_SEND: begin
            res_v = 1'b1;
            if (len > LEN_MAX) begin
              res_ev = EV_TOO_LONG;
            end else if (!found) begin
              res_ev = EV_NO_SLOT;
            end else begin
              seq_counter_next = seq_draw;
              mem_we = 1'b1;
              mem_wa = found_idx;
              mem_wd = '{age: AGE_AFTER_SEND, seq: seq_draw};
              res_ev = EV_ACCEPTED;
              res_idx = slot_field(found_idx);
              res_seq = seq_draw;
            end
          end
          ACT_ACK: begin
            res_v = 1'b1;
            if (found) begin
              mem_we = 1'b1;
              mem_wa = found_idx;
              mem_wd = '{age: 6'd0, seq: found_seq};
              res_ev = EV_ACK_HIT;
              res_idx = slot_field(found_idx);
              res_seq = found_seq;
            end else begin
              res_ev = EV_ACK_MISS;
              res_seq = ack;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_idx <= '0;
      proc_v <= 1'b0;
      found <= 1'b0;
      pend_v <= 1'b0;
      seq_counter <= 16'd1;
      strobe <= 1'b0;
      act <= ACT_NONE;
    end else begin
      state <= state_next;
      rd_idx <= rd_idx_next;
      proc_v <= proc_v_next;
      found <= found_next;
      pend_v <= pend_v_next;
      seq_counter <= seq_counter_next;
      strobe <= res_v;
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
    ack <= ack_next;
    proc_idx <= proc_idx_next;
    found_idx <= found_idx_next;
    found_seq <= found_seq_next;
    pend_ev <= pend_ev_next;
    pend_idx <= pend_idx_next;
    pend_seq <= pend_seq_next;
    event_res <= res_ev;
    slot_index <= res_idx;
    seq_out <= res_seq;
    last <= res_last;
  end

  a_seq_odd: assert property (@(posedge clk) disable iff (rst)
    (strobe && (event_res == EV_ACCEPTED)) |-> seq_out[0])
    else $error("assigned sequence number is even");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && (event_res != EV_RETX) && (event_res != EV_FINAL)) |-> last)
    else $error("single-result transfer not marked last");

  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && ((event_res == EV_TOO_LONG) || (event_res == EV_NO_SLOT)))
      |-> ((slot_index == 3'd0) && (seq_out == 16'd0)))
    else $error("rejected send carries slot or number");

  a_scan_write_tick: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == ST_SCAN)) |-> (act == ACT_TICK))
    else $error("memory written during a non-tick scan");

  a_busy_ends_fin: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(state) == ST_FIN))
    else $error("busy dropped outside the final step");

endmodule
